// ===== sv/pidhw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidhw_pkg
// Shared types, constants, saturation and magnitude helpers for the PID step block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidhw_pkg;

    // fixed point format of every field
    localparam int DW = 32;
    localparam int FB = 16;

    // 0.1 in Q16.16, rounded
    localparam logic signed [32:0] AW_Q = 33'sd6554;
    // 180 degrees in Q16.16
    localparam logic signed [63:0] H180 = 64'sd180 <<< FB;

    // command codes
    localparam logic [1:0] CMD_CLASSIC = 2'd0;
    localparam logic [1:0] CMD_VEL     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_RSVD    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_P_GAIN   = 3'd1;
    localparam logic [2:0] REG_I_GAIN   = 3'd2;
    localparam logic [2:0] REG_D_GAIN   = 3'd3;
    localparam logic [2:0] REG_DB_WIDTH = 3'd4;
    localparam logic [2:0] REG_DB_EN    = 3'd5;
    localparam logic [2:0] REG_HDG_EN   = 3'd6;

    typedef enum logic [5:0] {
        ST_IDLE, ST_ERR, ST_CLR, ST_DONE, ST_OUT,
        ST_C_MDT, ST_C_INT, ST_C_DIVS, ST_C_DIVW, ST_C_DER,
        ST_C_MPE, ST_C_ACC1, ST_C_MII, ST_C_ACC2, ST_C_MDD, ST_C_ACC3,
        ST_V_MPI, ST_V_U, ST_V_MAE, ST_V_T1, ST_V_MTI, ST_V_T3,
        ST_V_MUT, ST_V_RATE, ST_V_MRD, ST_V_INT, ST_V_MPE, ST_V_ACC1,
        ST_V_MII, ST_V_ACC2, ST_V_MDV, ST_V_ACC3
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_ERR, OP_MUL, OP_INT_ADD, OP_T_SAT, OP_U_SAT, OP_T3,
        OP_ACC_LD, OP_ACC_ADD, OP_ACC_SUB, OP_OUT, OP_DER, OP_CLEAR, OP_DIV_START
    } t_op;

    typedef enum logic [2:0] {
        A_E, A_P, A_I, A_D, A_T, A_U, A_AW
    } t_asel;

    typedef enum logic [2:0] {
        B_DT, B_E, B_MAGE, B_INT, B_T, B_DER, B_VEL, B_IG
    } t_bsel;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] p_gain;
        logic signed [31:0] i_gain;
        logic signed [31:0] d_gain;
        logic [30:0]        deadband_width;
        logic               deadband_enable;
        logic               heading_enable;
    } t_cfg;

    typedef struct packed {
        logic  in_ready;
        logic  load_in;
        logic  res_load;
        t_op   op;
        t_asel a_sel;
        t_bsel b_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] cmd;
        logic       dt_zero;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

    typedef struct packed {
        logic signed [31:0] control_out;
        logic signed [31:0] error_out;
        logic signed [31:0] integral_out;
        logic signed [31:0] derivative_out;
    } t_res;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // magnitude of a 32 bit signed value
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] y;
        y = x[31] ? (32'd0 - x) : x;
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pidhw_in_if.sv =====
// ----------------------------------------------------------------------------
// pidhw_in_if
// Input word channel: command, measurements and time step.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidhw_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [30:0]        time_step;

    modport source (output valid, command, position, velocity, time_step, input ready);
    modport sink   (input valid, command, position, velocity, time_step, output ready);
endinterface

`default_nettype wire

// ===== sv/pidhw_out_if.sv =====
// ----------------------------------------------------------------------------
// pidhw_out_if
// Result word channel: drive value and loop state.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidhw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] control_out;
    logic signed [31:0] error_out;
    logic signed [31:0] integral_out;
    logic signed [31:0] derivative_out;

    modport source (output valid, control_out, error_out, integral_out, derivative_out,
                    input ready);
    modport sink   (input valid, control_out, error_out, integral_out, derivative_out,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/pid_step_with_heading_wrap.sv =====
// ----------------------------------------------------------------------------
// pid_step_with_heading_wrap
// PID step with heading wrap, anti-windup integral and deadband, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per step: command, position, velocity, time_step.
//   o_out returns one word per step: drive, error, integral and derivative
//   after the update. Gains, setpoint and mode bits must be written over the APB
//   port only while idle, which the block does not enforce; pready is always high.
// Sequencing:
//   a classic step (command 0) waits on the bit-serial derivative divider,
//   which is skipped with a zero time step. Both loop steps, classic and
//   velocity (command 1), pass through one shared 32x32 rounding multiplier.
//   Clear is command 2; command 3 is unused. One word is in work at a time;
//   the next word is taken once the previous one is in the output register.
// Reset:
//   synchronous, active low; loop state and configuration registers go to zero.
// Stall:
//   the result word holds on o_out while ready is low; a finished step
//   waits for the output register before the next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_step_with_heading_wrap (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pidhw_in_if.sink         i_in,
    pidhw_out_if.source      o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    pidhw_pkg::t_cfg     r_cfg;
    pidhw_pkg::t_dp_cmd  dp_cmd;
    pidhw_pkg::t_dp_stat dp_stat;
    pidhw_pkg::t_res     res;
    logic                r_vld;
    logic [1:0]          cmd_q;
    logic                dt_zero, div_done, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                pidhw_pkg::REG_SETPOINT: r_cfg.setpoint        <= pwdata;
                pidhw_pkg::REG_P_GAIN:   r_cfg.p_gain          <= pwdata;
                pidhw_pkg::REG_I_GAIN:   r_cfg.i_gain          <= pwdata;
                pidhw_pkg::REG_D_GAIN:   r_cfg.d_gain          <= pwdata;
                pidhw_pkg::REG_DB_WIDTH: r_cfg.deadband_width  <= pwdata[30:0];
                pidhw_pkg::REG_DB_EN:    r_cfg.deadband_enable <= pwdata[0];
                pidhw_pkg::REG_HDG_EN:   r_cfg.heading_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            pidhw_pkg::REG_SETPOINT: prdata = r_cfg.setpoint;
            pidhw_pkg::REG_P_GAIN:   prdata = r_cfg.p_gain;
            pidhw_pkg::REG_I_GAIN:   prdata = r_cfg.i_gain;
            pidhw_pkg::REG_D_GAIN:   prdata = r_cfg.d_gain;
            pidhw_pkg::REG_DB_WIDTH: prdata = {1'b0, r_cfg.deadband_width};
            pidhw_pkg::REG_DB_EN:    prdata = {31'd0, r_cfg.deadband_enable};
            pidhw_pkg::REG_HDG_EN:   prdata = {31'd0, r_cfg.heading_enable};
            default:                 prdata = 32'd0;
        endcase
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (dp_cmd.res_load) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    assign dp_stat = '{in_valid: i_in.valid, cmd: cmd_q, dt_zero: dt_zero,
                       div_done: div_done, out_free: (!r_vld || o_out.ready)};

    pidhw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    pidhw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (dp_cmd),
        .i_command   (i_in.command),
        .i_position  (i_in.position),
        .i_velocity  (i_in.velocity),
        .i_time_step (i_in.time_step),
        .o_cmd       (cmd_q),
        .o_dt_zero   (dt_zero),
        .o_div_done  (div_done),
        .o_res       (res)
    );

    assign i_in.ready           = dp_cmd.in_ready;
    assign o_out.valid          = r_vld;
    assign o_out.control_out    = res.control_out;
    assign o_out.error_out      = res.error_out;
    assign o_out.integral_out   = res.integral_out;
    assign o_out.derivative_out = res.derivative_out;

endmodule

`default_nettype wire

// ===== sv/pidhw_div.sv =====
// ----------------------------------------------------------------------------
// pidhw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pidhw_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [48:0] i_dividend,
    input  wire logic [30:0] i_divisor,
    output logic             o_done,
    output logic [48:0]      o_quotient
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [31:0] r_rem, n_rem;
    logic [48:0] r_q, n_q;
    logic [30:0] r_dvs, n_dvs;
    logic [31:0] trial;
    logic        fits;

    // one shift and subtract step
    always_comb begin
        trial  = {r_rem[30:0], r_q[48]};
        fits   = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd48;
            n_rem  = 32'd0;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? (trial - {1'b0, r_dvs}) : trial;
            n_q   = {r_q[47:0], fits};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ===== sv/pidhw_dp.sv =====
// ----------------------------------------------------------------------------
// pidhw_dp
// Datapath: loop state, shared rounding multiplier, accumulator, divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pidhw_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pidhw_pkg::t_cfg    i_cfg,
    input  wire pidhw_pkg::t_dp_cmd i_cmd,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [31:0] i_position,
    input  wire logic signed [31:0] i_velocity,
    input  wire logic [30:0]        i_time_step,
    output logic [1:0]              o_cmd,
    output logic                    o_dt_zero,
    output logic                    o_div_done,
    output pidhw_pkg::t_res         o_res
);

    logic [1:0]         r_cmd;
    logic signed [31:0] r_pos, r_vel;
    logic [30:0]        r_dt;
    logic signed [31:0] r_err, r_int, r_prev, r_der, r_out, r_t, r_u;
    logic signed [32:0] r_diff;
    logic signed [48:0] r_prod;
    logic signed [51:0] r_acc;
    pidhw_pkg::t_res    r_res;

    logic signed [32:0] op_a, op_b, neg_a, neg_b;
    logic [31:0]        ma, mb;
    logic [63:0]        pmag;
    logic [47:0]        prnd;
    logic signed [48:0] prod;
    logic signed [31:0] prod_sat;
    logic signed [63:0] ev;
    logic signed [31:0] e_new;
    logic [32:0]        diff_mag;
    logic               div_done;
    logic [48:0]        quo;
    logic signed [49:0] quo_s;
    logic               in_db;

    // operand select
    always_comb begin
        case (i_cmd.a_sel)
            pidhw_pkg::A_E:  op_a = 33'(r_err);
            pidhw_pkg::A_P:  op_a = 33'(i_cfg.p_gain);
            pidhw_pkg::A_I:  op_a = 33'(i_cfg.i_gain);
            pidhw_pkg::A_D:  op_a = 33'(i_cfg.d_gain);
            pidhw_pkg::A_T:  op_a = 33'(r_t);
            pidhw_pkg::A_U:  op_a = 33'(r_u);
            pidhw_pkg::A_AW: op_a = pidhw_pkg::AW_Q;
            default:         op_a = 33'sd0;
        endcase
        case (i_cmd.b_sel)
            pidhw_pkg::B_DT:   op_b = $signed({2'b00, r_dt});
            pidhw_pkg::B_E:    op_b = 33'(r_err);
            pidhw_pkg::B_MAGE: op_b = $signed({1'b0, pidhw_pkg::mag32(r_err)});
            pidhw_pkg::B_INT:  op_b = 33'(r_int);
            pidhw_pkg::B_T:    op_b = 33'(r_t);
            pidhw_pkg::B_DER:  op_b = 33'(r_der);
            pidhw_pkg::B_VEL:  op_b = 33'(r_vel);
            pidhw_pkg::B_IG:   op_b = 33'(i_cfg.i_gain);
            default:           op_b = 33'sd0;
        endcase
    end

    // sign magnitude product, rounded half away from zero
    always_comb begin
        neg_a = -op_a;
        neg_b = -op_b;
        ma    = op_a[32] ? neg_a[31:0] : op_a[31:0];
        mb    = op_b[32] ? neg_b[31:0] : op_b[31:0];
        pmag  = ma * mb;
        prnd  = 48'((pmag + 64'd32768) >> pidhw_pkg::FB);
        prod  = (op_a[32] ^ op_b[32]) ? -$signed({1'b0, prnd}) : $signed({1'b0, prnd});
        prod_sat = pidhw_pkg::sat32(64'(r_prod));
    end

    // error with heading correction
    always_comb begin
        ev = 64'(i_cfg.setpoint) - 64'(r_pos);
        if (i_cfg.heading_enable) begin
            if (ev >= pidhw_pkg::H180) begin
                ev = ev - (pidhw_pkg::H180 <<< 1);
            end else if (ev <= -pidhw_pkg::H180) begin
                ev = ev + (pidhw_pkg::H180 <<< 1);
            end
        end
        e_new = pidhw_pkg::sat32(ev);
    end

    // derivative divider on magnitudes
    assign diff_mag = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
    assign quo_s    = r_diff[32] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign in_db    = i_cfg.deadband_enable && (r_cmd == pidhw_pkg::CMD_VEL)
                      && (pidhw_pkg::mag32(r_err) < {1'b0, i_cfg.deadband_width});

    pidhw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == pidhw_pkg::OP_DIV_START),
        .i_dividend ({diff_mag, 16'd0}),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_vel <= i_velocity;
            r_dt  <= i_time_step;
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err  <= '0;
            r_int  <= '0;
            r_prev <= '0;
            r_der  <= '0;
            r_out  <= '0;
        end else begin
            case (i_cmd.op)
                pidhw_pkg::OP_ERR: r_err <= e_new;
                pidhw_pkg::OP_INT_ADD:
                    r_int <= pidhw_pkg::sat32(64'(r_int) + 64'(prod_sat));
                pidhw_pkg::OP_DER: begin
                    r_prev <= r_err;
                    if (r_dt == 31'd0) begin
                        r_der <= (r_diff > 0) ? 32'sh7fff_ffff :
                                 (r_diff < 0) ? 32'sh8000_0000 : 32'sd0;
                    end else begin
                        r_der <= pidhw_pkg::sat32(64'(quo_s));
                    end
                end
                pidhw_pkg::OP_OUT:
                    r_out <= in_db ? 32'sd0 : pidhw_pkg::sat32(64'(r_acc));
                pidhw_pkg::OP_CLEAR: begin
                    r_err  <= '0;
                    r_int  <= '0;
                    r_prev <= '0;
                    r_der  <= '0;
                end
                default: ;
            endcase
        end
    end

    // scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pidhw_pkg::OP_ERR) begin
            r_diff <= 33'(e_new) - 33'(r_prev);
        end
        if (i_cmd.op == pidhw_pkg::OP_MUL) begin
            r_prod <= prod;
        end
        case (i_cmd.op)
            pidhw_pkg::OP_T_SAT:   r_t <= prod_sat;
            pidhw_pkg::OP_T3:      r_t <= pidhw_pkg::sat32(64'(r_err) - 64'(prod_sat));
            pidhw_pkg::OP_U_SAT:   r_u <= prod_sat;
            pidhw_pkg::OP_ACC_LD:  r_acc <= 52'(r_prod);
            pidhw_pkg::OP_ACC_ADD: r_acc <= r_acc + 52'(r_prod);
            pidhw_pkg::OP_ACC_SUB: r_acc <= r_acc - 52'(r_prod);
            default: ;
        endcase
        if (i_cmd.res_load) begin
            r_res <= '{control_out: r_out, error_out: r_err,
                       integral_out: r_int, derivative_out: r_der};
        end
    end

    assign o_cmd      = r_cmd;
    assign o_dt_zero  = (r_dt == 31'd0);
    assign o_div_done = div_done;
    assign o_res      = r_res;

endmodule

`default_nettype wire

// ===== sv/pidhw_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidhw_ctrl
// Sequencer: steps the datapath through one PID update, clear or no-op per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module pidhw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pidhw_pkg::t_dp_stat i_stat,
    output pidhw_pkg::t_dp_cmd       o_cmd
);

    pidhw_pkg::t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pidhw_pkg::ST_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = pidhw_pkg::ST_ERR;
                end
            end
            pidhw_pkg::ST_ERR: begin
                case (i_stat.cmd)
                    pidhw_pkg::CMD_CLASSIC: n_state = pidhw_pkg::ST_C_MDT;
                    pidhw_pkg::CMD_VEL:     n_state = pidhw_pkg::ST_V_MPI;
                    pidhw_pkg::CMD_CLEAR:   n_state = pidhw_pkg::ST_CLR;
                    default:                n_state = pidhw_pkg::ST_DONE;
                endcase
            end
            pidhw_pkg::ST_C_MDT:  n_state = pidhw_pkg::ST_C_INT;
            pidhw_pkg::ST_C_INT:  n_state = pidhw_pkg::ST_C_DIVS;
            pidhw_pkg::ST_C_DIVS:
                n_state = i_stat.dt_zero ? pidhw_pkg::ST_C_DER : pidhw_pkg::ST_C_DIVW;
            pidhw_pkg::ST_C_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = pidhw_pkg::ST_C_DER;
                end
            end
            pidhw_pkg::ST_C_DER:  n_state = pidhw_pkg::ST_C_MPE;
            pidhw_pkg::ST_C_MPE:  n_state = pidhw_pkg::ST_C_ACC1;
            pidhw_pkg::ST_C_ACC1: n_state = pidhw_pkg::ST_C_MII;
            pidhw_pkg::ST_C_MII:  n_state = pidhw_pkg::ST_C_ACC2;
            pidhw_pkg::ST_C_ACC2: n_state = pidhw_pkg::ST_C_MDD;
            pidhw_pkg::ST_C_MDD:  n_state = pidhw_pkg::ST_C_ACC3;
            pidhw_pkg::ST_C_ACC3: n_state = pidhw_pkg::ST_OUT;
            pidhw_pkg::ST_V_MPI:  n_state = pidhw_pkg::ST_V_U;
            pidhw_pkg::ST_V_U:    n_state = pidhw_pkg::ST_V_MAE;
            pidhw_pkg::ST_V_MAE:  n_state = pidhw_pkg::ST_V_T1;
            pidhw_pkg::ST_V_T1:   n_state = pidhw_pkg::ST_V_MTI;
            pidhw_pkg::ST_V_MTI:  n_state = pidhw_pkg::ST_V_T3;
            pidhw_pkg::ST_V_T3:   n_state = pidhw_pkg::ST_V_MUT;
            pidhw_pkg::ST_V_MUT:  n_state = pidhw_pkg::ST_V_RATE;
            pidhw_pkg::ST_V_RATE: n_state = pidhw_pkg::ST_V_MRD;
            pidhw_pkg::ST_V_MRD:  n_state = pidhw_pkg::ST_V_INT;
            pidhw_pkg::ST_V_INT:  n_state = pidhw_pkg::ST_V_MPE;
            pidhw_pkg::ST_V_MPE:  n_state = pidhw_pkg::ST_V_ACC1;
            pidhw_pkg::ST_V_ACC1: n_state = pidhw_pkg::ST_V_MII;
            pidhw_pkg::ST_V_MII:  n_state = pidhw_pkg::ST_V_ACC2;
            pidhw_pkg::ST_V_ACC2: n_state = pidhw_pkg::ST_V_MDV;
            pidhw_pkg::ST_V_MDV:  n_state = pidhw_pkg::ST_V_ACC3;
            pidhw_pkg::ST_V_ACC3: n_state = pidhw_pkg::ST_OUT;
            pidhw_pkg::ST_OUT:    n_state = pidhw_pkg::ST_DONE;
            pidhw_pkg::ST_CLR:    n_state = pidhw_pkg::ST_DONE;
            pidhw_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = pidhw_pkg::ST_IDLE;
                end
            end
            default: n_state = pidhw_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = pidhw_pkg::OP_NONE;
        o_cmd.a_sel    = pidhw_pkg::A_E;
        o_cmd.b_sel    = pidhw_pkg::B_DT;
        o_cmd.in_ready = (r_state == pidhw_pkg::ST_IDLE);
        o_cmd.load_in  = o_cmd.in_ready && i_stat.in_valid;
        case (r_state)
            // only the two loop steps take a new error
            pidhw_pkg::ST_ERR:
                o_cmd.op = (i_stat.cmd == pidhw_pkg::CMD_CLASSIC ||
                            i_stat.cmd == pidhw_pkg::CMD_VEL) ? pidhw_pkg::OP_ERR
                                                              : pidhw_pkg::OP_NONE;
            pidhw_pkg::ST_CLR:    o_cmd.op = pidhw_pkg::OP_CLEAR;
            pidhw_pkg::ST_OUT:    o_cmd.op = pidhw_pkg::OP_OUT;
            pidhw_pkg::ST_DONE:   o_cmd.res_load = i_stat.out_free;
            pidhw_pkg::ST_C_MDT: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_E;
                o_cmd.b_sel = pidhw_pkg::B_DT;
            end
            pidhw_pkg::ST_C_INT:  o_cmd.op = pidhw_pkg::OP_INT_ADD;
            pidhw_pkg::ST_C_DIVS:
                o_cmd.op = i_stat.dt_zero ? pidhw_pkg::OP_NONE : pidhw_pkg::OP_DIV_START;
            pidhw_pkg::ST_C_DER:  o_cmd.op = pidhw_pkg::OP_DER;
            pidhw_pkg::ST_C_MPE, pidhw_pkg::ST_V_MPE: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_P;
                o_cmd.b_sel = pidhw_pkg::B_E;
            end
            pidhw_pkg::ST_C_ACC1, pidhw_pkg::ST_V_ACC1: o_cmd.op = pidhw_pkg::OP_ACC_LD;
            pidhw_pkg::ST_C_MII, pidhw_pkg::ST_V_MII: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_I;
                o_cmd.b_sel = pidhw_pkg::B_INT;
            end
            pidhw_pkg::ST_C_ACC2, pidhw_pkg::ST_V_ACC2,
            pidhw_pkg::ST_C_ACC3: o_cmd.op = pidhw_pkg::OP_ACC_ADD;
            pidhw_pkg::ST_C_MDD: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_D;
                o_cmd.b_sel = pidhw_pkg::B_DER;
            end
            pidhw_pkg::ST_V_MPI: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_P;
                o_cmd.b_sel = pidhw_pkg::B_IG;
            end
            pidhw_pkg::ST_V_U:    o_cmd.op = pidhw_pkg::OP_U_SAT;
            pidhw_pkg::ST_V_MAE: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_AW;
                o_cmd.b_sel = pidhw_pkg::B_MAGE;
            end
            pidhw_pkg::ST_V_T1, pidhw_pkg::ST_V_RATE: o_cmd.op = pidhw_pkg::OP_T_SAT;
            pidhw_pkg::ST_V_MTI: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_T;
                o_cmd.b_sel = pidhw_pkg::B_INT;
            end
            pidhw_pkg::ST_V_T3:   o_cmd.op = pidhw_pkg::OP_T3;
            pidhw_pkg::ST_V_MUT: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_U;
                o_cmd.b_sel = pidhw_pkg::B_T;
            end
            pidhw_pkg::ST_V_MRD: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_T;
                o_cmd.b_sel = pidhw_pkg::B_DT;
            end
            pidhw_pkg::ST_V_INT:  o_cmd.op = pidhw_pkg::OP_INT_ADD;
            pidhw_pkg::ST_V_MDV: begin
                o_cmd.op = pidhw_pkg::OP_MUL;
                o_cmd.a_sel = pidhw_pkg::A_D;
                o_cmd.b_sel = pidhw_pkg::B_VEL;
            end
            pidhw_pkg::ST_V_ACC3: o_cmd.op = pidhw_pkg::OP_ACC_SUB;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidhw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a taken word always starts a step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pidhw_pkg::ST_IDLE && i_stat.in_valid) |=> (r_state == pidhw_pkg::ST_ERR))
        else $error("accepted word did not start a step");

    // divider finishes only while waited for
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == pidhw_pkg::ST_C_DIVW))
        else $error("divider done outside wait state");

    // result register never overwritten while still held
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (i_stat.out_free && r_state == pidhw_pkg::ST_DONE))
        else $error("result loaded over a pending word");

endmodule

`default_nettype wire
